/* hw/rtl/gps_pkg.sv */
`default_nettype none

package gps_pkg;

    // Coordinate math width: holds any map column or row plus the largest distance
    localparam int CRD_W      = 13;
    // Word-column index within a bitmap row (column >> 6)
    localparam int WCOL_W     = 7;
    // Bit position within a 64-bit bitmap word
    localparam int BIT_W      = 6;
    localparam int WORD_W     = 64;
    // Clamped suppression distance
    localparam int DIST_W     = 6;
    // Frame tag stored with each bitmap word
    localparam int EPOCH_W    = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROB_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LIMIT     = 2'd2;

    localparam logic [15:0] THR_RST  = 16'd32768;
    localparam logic [4:0]  DIST_RST = 5'd8;
    localparam logic [10:0] LIM_RST  = 11'd64;

    // Input op codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic        op;
        logic [9:0]  pix_x;
        logic [8:0]  pix_y;
        logic [15:0] prob;
    } t_cand;

    typedef struct packed {
        logic [9:0] seed_x;
        logic [8:0] seed_y;
        logic [9:0] seed_index;
    } t_seed;

    // Sequencer to bitmap controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic new_frame;
    } t_bm_ctl;

endpackage

`default_nettype wire

/* hw/rtl/gps_stream_if.sv */
`default_nettype none

// valid/ready channel; one beat moves one payload
interface gps_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/gps_window.sv */
`default_nettype none

// Suppression square around a seed, clipped to the map
module gps_window #(
    parameter int MAP_WIDTH  = 800,
    parameter int MAP_HEIGHT = 320
) (
    input  wire logic [gps_pkg::CRD_W-1:0]  i_x,
    input  wire logic [gps_pkg::CRD_W-1:0]  i_y,
    input  wire logic [gps_pkg::DIST_W-1:0] i_d,
    output logic      [gps_pkg::CRD_W-1:0]  o_x0,
    output logic      [gps_pkg::CRD_W-1:0]  o_x1,
    output logic      [gps_pkg::CRD_W-1:0]  o_y0,
    output logic      [gps_pkg::CRD_W-1:0]  o_y1
);
    localparam logic [gps_pkg::CRD_W-1:0] XMAX = gps_pkg::CRD_W'(MAP_WIDTH - 1);
    localparam logic [gps_pkg::CRD_W-1:0] YMAX = gps_pkg::CRD_W'(MAP_HEIGHT - 1);

    logic [gps_pkg::CRD_W-1:0] d_ext;
    logic [gps_pkg::CRD_W-1:0] x_hi;
    logic [gps_pkg::CRD_W-1:0] y_hi;

    assign d_ext = gps_pkg::CRD_W'(i_d);
    assign x_hi  = i_x + d_ext;
    assign y_hi  = i_y + d_ext;

    // low edges saturate at zero, high edges at the last column/row
    assign o_x0 = (i_x > d_ext) ? (i_x - d_ext) : '0;
    assign o_y0 = (i_y > d_ext) ? (i_y - d_ext) : '0;
    assign o_x1 = (x_hi > XMAX) ? XMAX : x_hi;
    assign o_y1 = (y_hi > YMAX) ? YMAX : y_hi;

endmodule

`default_nettype wire

/* hw/rtl/gps_bitmap.sv */
`default_nettype none

// Occupancy bitmap: one 64-bit word per entry, tagged with the frame epoch.
// A word whose tag differs from the current epoch reads as all zero, so a
// frame start needs no sweep. When the epoch wraps, a clearing pass rewrites
// every tag to zero; the same pass runs after reset.
module gps_bitmap #(
    parameter int DEPTH  = 4160,
    parameter int ADDR_W = 13
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire gps_pkg::t_bm_ctl            i_ctl,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [gps_pkg::WORD_W-1:0]  i_wr_mask,
    output logic      [gps_pkg::WORD_W-1:0]  o_rd_bits,
    output logic                             o_busy
);
    localparam int ENTRY_W = gps_pkg::EPOCH_W + gps_pkg::WORD_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [gps_pkg::EPOCH_W-1:0] EPOCH_FIRST = gps_pkg::EPOCH_W'(1);

    logic [ENTRY_W-1:0]          mem [DEPTH];
    logic [ENTRY_W-1:0]          r_rd;
    logic                        r_busy;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic [gps_pkg::EPOCH_W-1:0] r_epoch;

    logic                        we;
    logic [ADDR_W-1:0]           wa;
    logic [ENTRY_W-1:0]          wd;

    // stale tags read as empty
    assign o_rd_bits = (r_rd[ENTRY_W-1 -: gps_pkg::EPOCH_W] == r_epoch)
                     ? r_rd[gps_pkg::WORD_W-1:0] : '0;
    assign o_busy    = r_busy;

    // write port: clearing pass or merge of the word read the cycle before
    assign we = r_busy | i_ctl.wr_en;
    assign wa = r_busy ? r_clr_addr : i_wr_addr;
    assign wd = r_busy ? '0 : {r_epoch, o_rd_bits | i_wr_mask};

    // memory array
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_ctl.rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    // epoch and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
        end else if (r_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_busy  <= 1'b0;
                r_epoch <= EPOCH_FIRST;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end else if (i_ctl.new_frame) begin
            if (&r_epoch) begin
                r_busy     <= 1'b1;
                r_clr_addr <= '0;
            end else begin
                r_epoch <= r_epoch + EPOCH_FIRST;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/greedy_point_suppression_unit.sv */
`default_nettype none

// Greedy point suppression. Candidates arrive on i_cand in falling probability
// order; a beat with op = frame start clears the occupancy map and seed count.
// A candidate on the map, above the threshold, under the seed limit and on an
// unmarked pixel leaves as one beat on o_seed, and the clipped square of side
// 2*min_distance+1 around it is marked, row by row in 64-pixel words (one or
// two per row), one word per cycle through the bitmap's read-modify-write path.
// An output stall holds the sequencer only when a seed is ready while the
// previous one is still waiting. After reset, and at every 255th frame start,
// the bitmap runs a clearing pass over all MAP_HEIGHT * ceil(MAP_WIDTH / 64)
// words (4160 by default) during which no candidate is taken; configuration
// writes are taken at any time.
module greedy_point_suppression_unit #(
    parameter int MAP_WIDTH    = 800,
    parameter int MAP_HEIGHT   = 320,
    parameter int MAX_DISTANCE = 31,
    parameter int SEEDS_MAX    = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [gps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    gps_stream_if.sink                            i_cand,
    gps_stream_if.source                          o_seed
);
    localparam int CW        = gps_pkg::CRD_W;
    localparam int ROW_WORDS = (MAP_WIDTH + 63) / 64;
    localparam int MAP_WORDS = MAP_HEIGHT * ROW_WORDS;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int PW        = CW + gps_pkg::WCOL_W;
    localparam int LIM_W     = 13;

    localparam logic [CW-1:0]    X_END     = CW'(MAP_WIDTH);
    localparam logic [CW-1:0]    Y_END     = CW'(MAP_HEIGHT);
    localparam logic [PW-1:0]    ROW_STEP  = PW'(ROW_WORDS);
    localparam logic [LIM_W-1:0] SEED_CAP  = LIM_W'(SEEDS_MAX);
    localparam logic [gps_pkg::DIST_W-1:0] DIST_CAP = gps_pkg::DIST_W'(MAX_DISTANCE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_LOOK,
        S_MARK,
        S_DRAIN
    } t_state;

    // configuration
    logic [15:0] r_thr;
    logic [4:0]  r_dist;
    logic [10:0] r_lim;

    // sequencer
    t_state                    r_state;
    logic [CW-1:0]             r_x;
    logic [CW-1:0]             r_y;
    logic [15:0]               r_prob;
    logic [10:0]               r_count;
    logic [CW-1:0]             r_x0;
    logic [CW-1:0]             r_x1;
    logic [CW-1:0]             r_y0;
    logic [CW-1:0]             r_y1;
    logic [gps_pkg::WCOL_W-1:0] r_wx0;
    logic [gps_pkg::WCOL_W-1:0] r_wx1;
    logic [AW-1:0]             r_mrow;
    logic [gps_pkg::WCOL_W-1:0] r_mcol;
    logic [CW-1:0]             r_cy;
    logic                      r_pend_v;
    logic [AW-1:0]             r_pend_addr;
    logic [gps_pkg::WORD_W-1:0] r_pend_mask;
    logic                      r_out_valid;
    gps_pkg::t_seed            r_seed;

    // combinational
    logic                      cand_acc;
    logic                      bm_busy;
    gps_pkg::t_bm_ctl          bm_ctl;
    logic [AW-1:0]             bm_rd_addr;
    logic [gps_pkg::WORD_W-1:0] bm_rd_bits;
    logic [gps_pkg::DIST_W-1:0] dist_eff;
    logic [LIM_W-1:0]          lim;
    logic [10:0]               lim_raw;
    logic                      reject;
    logic [PW-1:0]             chk_prod;
    logic [PW-1:0]             row0_prod;
    logic [AW-1:0]             cur_addr;
    logic [gps_pkg::BIT_W-1:0] mask_lo;
    logic [gps_pkg::BIT_W-1:0] mask_hi;
    logic [gps_pkg::WORD_W-1:0] mask;
    logic                      out_free;
    logic                      seed_emit;
    logic [CW-1:0]             win_x0;
    logic [CW-1:0]             win_x1;
    logic [CW-1:0]             win_y0;
    logic [CW-1:0]             win_y1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= gps_pkg::THR_RST;
            r_dist <= gps_pkg::DIST_RST;
            r_lim  <= gps_pkg::LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gps_pkg::CFG_PROB_THRESHOLD: r_thr  <= i_cfg_data;
                gps_pkg::CFG_MIN_DISTANCE:   r_dist <= i_cfg_data[4:0];
                gps_pkg::CFG_SEED_LIMIT:     r_lim  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // effective distance and seed limit
    assign dist_eff = ({1'b0, r_dist} > DIST_CAP) ? DIST_CAP : {1'b0, r_dist};
    assign lim_raw  = (r_lim == '0) ? 11'd1 : r_lim;
    assign lim      = (LIM_W'(lim_raw) > SEED_CAP) ? SEED_CAP : LIM_W'(lim_raw);

    // candidate screening, before any bitmap access
    assign reject = (r_x >= X_END) || (r_y >= Y_END) || (r_prob <= r_thr)
                 || (LIM_W'(r_count) >= lim);

    gps_window #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_window (
        .i_x  (r_x),
        .i_y  (r_y),
        .i_d  (dist_eff),
        .o_x0 (win_x0),
        .o_x1 (win_x1),
        .o_y0 (win_y0),
        .o_y1 (win_y1)
    );

    // word addresses
    assign chk_prod  = PW'(r_y) * ROW_STEP + PW'(r_x[CW-1:gps_pkg::BIT_W]);
    assign row0_prod = PW'(r_y0) * ROW_STEP;
    assign cur_addr  = r_mrow + AW'(r_mcol);

    // bit mask of the square's columns within the current word
    assign mask_lo = (r_mcol == r_wx0) ? r_x0[gps_pkg::BIT_W-1:0] : '0;
    assign mask_hi = (r_mcol == r_wx1) ? r_x1[gps_pkg::BIT_W-1:0] : '1;
    assign mask    = ({gps_pkg::WORD_W{1'b1}} << mask_lo)
                   & ({gps_pkg::WORD_W{1'b1}} >> (gps_pkg::BIT_W'(63) - mask_hi));

    assign cand_acc       = i_cand.valid && i_cand.ready;
    assign i_cand.ready   = (r_state == S_IDLE) && !bm_busy;
    assign out_free       = !r_out_valid || o_seed.ready;
    assign o_seed.valid   = r_out_valid;
    assign o_seed.data    = r_seed;

    // unmarked pixel with room in the output register
    assign seed_emit = (r_state == S_LOOK) && !bm_rd_bits[r_x[gps_pkg::BIT_W-1:0]]
                    && out_free;

    // bitmap port control
    always_comb begin
        bm_ctl.new_frame = cand_acc && (i_cand.data.op == gps_pkg::OP_FRAME);
        bm_ctl.rd_en     = ((r_state == S_CHK) && !reject) || (r_state == S_MARK);
        bm_ctl.wr_en     = ((r_state == S_MARK) && r_pend_v) || (r_state == S_DRAIN);
        bm_rd_addr       = (r_state == S_MARK) ? cur_addr : chk_prod[AW-1:0];
    end

    gps_bitmap #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (AW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (bm_ctl),
        .i_rd_addr (bm_rd_addr),
        .i_wr_addr (r_pend_addr),
        .i_wr_mask (r_pend_mask),
        .o_rd_bits (bm_rd_bits),
        .o_busy    (bm_busy)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output beat: load a new seed or retire the one taken
            if (seed_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_seed.valid && o_seed.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cand_acc) begin
                        if (i_cand.data.op == gps_pkg::OP_FRAME) begin
                            r_count <= '0;
                        end else begin
                            r_x     <= CW'(i_cand.data.pix_x);
                            r_y     <= CW'(i_cand.data.pix_y);
                            r_prob  <= i_cand.data.prob;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    // read of the candidate's word is issued here
                    r_x0    <= win_x0;
                    r_x1    <= win_x1;
                    r_y0    <= win_y0;
                    r_y1    <= win_y1;
                    r_wx0   <= win_x0[CW-1:gps_pkg::BIT_W];
                    r_wx1   <= win_x1[CW-1:gps_pkg::BIT_W];
                    r_state <= reject ? S_IDLE : S_LOOK;
                end
                S_LOOK: begin
                    if (bm_rd_bits[r_x[gps_pkg::BIT_W-1:0]]) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_seed.seed_x     <= r_x[9:0];
                        r_seed.seed_y     <= r_y[8:0];
                        r_seed.seed_index <= r_count[9:0];
                        r_count           <= r_count + 11'd1;
                        r_mrow            <= row0_prod[AW-1:0];
                        r_mcol            <= r_wx0;
                        r_cy              <= r_y0;
                        r_pend_v          <= 1'b0;
                        r_state           <= S_MARK;
                    end
                end
                S_MARK: begin
                    // read this word, write back the one read last cycle
                    r_pend_v    <= 1'b1;
                    r_pend_addr <= cur_addr;
                    r_pend_mask <= mask;
                    if (r_mcol == r_wx1) begin
                        if (r_cy == r_y1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_mcol <= r_wx0;
                            r_mrow <= r_mrow + AW'(ROW_WORDS);
                            r_cy   <= r_cy + CW'(1);
                        end
                    end else begin
                        r_mcol <= r_mcol + gps_pkg::WCOL_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_pend_v <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* tb/greedy_point_suppression_unit_tb.sv */
`default_nettype none

module greedy_point_suppression_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gps_pkg::*;

    localparam int MAP_W     = 800;
    localparam int MAP_H     = 320;
    localparam int MAX_DIST  = 31;
    localparam int SEEDS_MAX = 1024;

    // index past the register list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 1500;
    localparam int PHASE_ITEMS    = 85;
    localparam int NUM_PHASES     = 6;
    localparam int IDLE_LIGHT     = 21;
    localparam int IDLE_HEAVY     = 83;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gps_stream_if #(.t_payload(t_cand)) cand_if ();
    gps_stream_if #(.t_payload(t_seed)) seed_if ();

    greedy_point_suppression_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cand      (cand_if),
        .o_seed      (seed_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: occupancy bitmap, seed count and register copies
    bit [MAP_W-1:0] marked_rows [MAP_H];
    logic [10:0]    seeds_in_frame = '0;
    logic [15:0]    thr_reg   = THR_RST;
    logic [4:0]     dist_reg  = DIST_RST;
    logic [10:0]    limit_reg = LIM_RST;

    t_cand pending_cands [$];
    t_seed expected_seeds [$];

    int unsigned src_idle_pct = IDLE_LIGHT;
    int unsigned snk_idle_pct = IDLE_HEAVY;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    logic        hold_request = 1'b0;
    logic        hold_taken = 1'b0;

    // Greedy suppression of one candidate; queues the seed it yields, if any
    task automatic predict_seed(input t_cand c);
        int unsigned lim, d, x0, x1, y0, y1;
        bit [MAP_W-1:0] span;
        t_seed s;
        if (c.op == OP_FRAME) begin
            foreach (marked_rows[r]) marked_rows[r] = '0;
            seeds_in_frame = '0;
            return;
        end
        if (c.pix_x >= MAP_W || c.pix_y >= MAP_H || c.prob <= thr_reg) return;
        lim = (limit_reg == 0) ? 1 : limit_reg;
        if (lim > SEEDS_MAX) lim = SEEDS_MAX;
        if (seeds_in_frame >= lim || marked_rows[c.pix_y][c.pix_x]) return;

        s.seed_x     = c.pix_x;
        s.seed_y     = c.pix_y;
        s.seed_index = seeds_in_frame[9:0];
        expected_seeds = {expected_seeds, s};
        seeds_in_frame = seeds_in_frame + 11'd1;

        // mark the clipped square around the seed
        d  = (dist_reg > MAX_DIST) ? MAX_DIST : dist_reg;
        x0 = (c.pix_x > d) ? c.pix_x - d : 0;
        y0 = (c.pix_y > d) ? c.pix_y - d : 0;
        x1 = (c.pix_x + d > MAP_W - 1) ? MAP_W - 1 : c.pix_x + d;
        y1 = (c.pix_y + d > MAP_H - 1) ? MAP_H - 1 : c.pix_y + d;
        span = '0;
        for (int unsigned cx = x0; cx <= x1; cx++) span[cx] = 1'b1;
        for (int unsigned cy = y0; cy <= y1; cy++) marked_rows[cy] |= span;
    endtask

    // Candidate driver: valid holds until the beat is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cand_if.valid <= 1'b0;
        end else if (!cand_if.valid || cand_if.ready) begin
            if (pending_cands.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cand_if.valid <= 1'b1;
                cand_if.data  <= pending_cands.pop_front();
            end else begin
                cand_if.valid <= 1'b0;
            end
        end
    end

    // Seed sink ready, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_if.ready <= 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= LONG_HOLD;
            seed_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            seed_if.ready <= 1'b0;
        end else begin
            seed_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Predict on each candidate beat, then check each seed beat
    always @(posedge i_clk) begin : check_seeds
        t_seed want;
        t_seed got;
        if (i_rst_n) begin
            if (cand_if.valid && cand_if.ready) predict_seed(cand_if.data);
            if (seed_if.valid && seed_if.ready) begin
                got = seed_if.data;
                if (expected_seeds.size() == 0) begin
                    $error("unexpected seed beat: x %0d y %0d index %0d",
                           got.seed_x, got.seed_y, got.seed_index);
                    mismatch_count++;
                end else begin
                    want = expected_seeds.pop_front();
                    if (got.seed_x !== want.seed_x) begin
                        $error("seed_x expected %0d got %0d", want.seed_x, got.seed_x);
                        mismatch_count++;
                    end
                    if (got.seed_y !== want.seed_y) begin
                        $error("seed_y expected %0d got %0d", want.seed_y, got.seed_y);
                        mismatch_count++;
                    end
                    if (got.seed_index !== want.seed_index) begin
                        $error("seed_index expected %0d got %0d",
                               want.seed_index, got.seed_index);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (cand_if.valid && cand_if.ready) || (seed_if.valid && seed_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("greedy_point_suppression_unit: mismatch");
            $finish;
        end
    end

    task automatic queue_item(input logic op, input int unsigned x, input int unsigned y,
                              input int unsigned p);
        t_cand c;
        c.op    = op;
        c.pix_x = x[9:0];
        c.pix_y = y[8:0];
        c.prob  = p[15:0];
        pending_cands = {pending_cands, c};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_PROB_THRESHOLD: thr_reg   = val;
            CFG_MIN_DISTANCE:   dist_reg  = val[4:0];
            CFG_SEED_LIMIT:     limit_reg = val[10:0];
            default: ;
        endcase
    endtask

    // Junk goes in the bits above each register's width
    task automatic set_regs(input int unsigned thr, input int unsigned dist_val,
                            input int unsigned lim);
        logic [CFG_DATA_W-1:0] dist_word, lim_word;
        dist_word       = $urandom;
        dist_word[4:0]  = dist_val[4:0];
        lim_word        = $urandom;
        lim_word[10:0]  = lim[10:0];
        write_reg(CFG_PROB_THRESHOLD, thr[15:0]);
        write_reg(CFG_MIN_DISTANCE, dist_word);
        write_reg(CFG_SEED_LIMIT, lim_word);
        write_reg(CFG_UNUSED, $urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drained: nothing queued, nothing offered, no seed outstanding
    task automatic wait_idle();
        while (pending_cands.size() != 0 || cand_if.valid || expected_seeds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One frame of candidates in falling probability, with clusters and noise
    task automatic queue_frame(input int unsigned n, input bit with_start,
                               inout int unsigned counted);
        int x, y, k, reach;
        int unsigned p, roll;
        int xs [$];
        int ys [$];
        reach = dist_reg + 2;
        if (with_start) begin
            queue_item(OP_FRAME, $urandom_range(1023), $urandom_range(511),
                       $urandom_range(65535));
            counted++;
        end
        p = $urandom_range(65535, 12288);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            x = $urandom_range(MAP_W - 1);
            y = $urandom_range(MAP_H - 1);
            if (roll < 35 && xs.size() != 0) begin
                // near an earlier candidate, often inside its square
                k = $urandom_range(xs.size() - 1);
                x = xs[k] + int'($urandom_range(2 * reach)) - reach;
                y = ys[k] + int'($urandom_range(2 * reach)) - reach;
                x = (x < 0) ? 0 : (x > MAP_W - 1) ? MAP_W - 1 : x;
                y = (y < 0) ? 0 : (y > MAP_H - 1) ? MAP_H - 1 : y;
            end else if (roll < 43) begin
                if ($urandom_range(1)) x = $urandom_range(1) ? 0 : MAP_W - 1;
                if ($urandom_range(1)) y = $urandom_range(1) ? 0 : MAP_H - 1;
            end else if (roll < 48) begin
                if ($urandom_range(1)) x = $urandom_range(1023, MAP_W);
                else y = $urandom_range(511, MAP_H);
            end
            p = $urandom_range(1200) >= p ? 0 : p - $urandom_range(1200);
            queue_item(OP_PIXEL, x, y, ($urandom_range(99) < 8) ? $urandom_range(65535) : p);
            if (x < MAP_W && y < MAP_H) begin
                xs = {xs, x};
                ys = {ys, y};
                counted++;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned counted;
        cand_if.valid = 1'b0;
        cand_if.data  = '0;
        seed_if.ready = 1'b0;
        foreach (marked_rows[r]) marked_rows[r] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: corners, off map, threshold edge, suppression
        queue_item(OP_FRAME, 1023, 511, 16'hFFFF);
        queue_item(OP_PIXEL, 0, 0, 16'hFFFF);
        queue_item(OP_PIXEL, MAP_W - 1, MAP_H - 1, 16'hFFF0);
        queue_item(OP_PIXEL, MAP_W, 10, 16'hFF00);
        queue_item(OP_PIXEL, 10, MAP_H, 16'hFF00);
        queue_item(OP_PIXEL, 1023, 511, 16'hFF00);
        queue_item(OP_PIXEL, 400, 160, 32768);
        queue_item(OP_PIXEL, 400, 160, 32769);
        queue_item(OP_PIXEL, 408, 152, 32769);
        queue_item(OP_PIXEL, 409, 160, 32769);
        queue_item(OP_PIXEL, 8, 8, 32769);
        queue_item(OP_PIXEL, MAP_W - 9, MAP_H - 9, 32769);
        queue_item(OP_PIXEL, 0, 0, 16'hFFFF);
        wait_idle();

        // zero seed limit acts as one; zero threshold still rejects prob 0
        set_regs(16'h0000, MAX_DIST, 0);
        queue_item(OP_FRAME, 0, 0, 0);
        queue_item(OP_PIXEL, 500, 100, 1);
        queue_item(OP_PIXEL, 100, 200, 5);
        queue_item(OP_FRAME, 0, 0, 0);
        queue_item(OP_PIXEL, 100, 200, 0);
        queue_item(OP_PIXEL, 100, 200, 1);
        wait_idle();

        // full threshold passes nothing; then zero distance marks one pixel
        set_regs(16'hFFFF, 0, 2047);
        queue_item(OP_FRAME, 0, 0, 0);
        queue_item(OP_PIXEL, 5, 5, 16'hFFFF);
        wait_idle();
        set_regs(16'hFFFE, 0, 2047);
        queue_item(OP_PIXEL, 5, 5, 16'hFFFF);
        queue_item(OP_PIXEL, 6, 5, 16'hFFFF);
        queue_item(OP_PIXEL, 5, 5, 16'hFFFF);
        wait_idle();

        // Random phases over several settings and idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_regs(16'h8000, 8, 64);
                1: set_regs(16'h2000, MAX_DIST, 2047);
                2: set_regs(16'h0000, 0, SEEDS_MAX);
                3: set_regs(16'hC000, 5, 3);
                4: set_regs(16'h0400, 2, SEEDS_MAX);
                default: set_regs($urandom_range(16'hA000), $urandom_range(MAX_DIST),
                                  $urandom_range(2047));
            endcase
            if (ph < 2) begin
                src_idle_pct = IDLE_LIGHT;
                snk_idle_pct = IDLE_HEAVY;
            end else if (ph < 4) begin
                src_idle_pct = IDLE_HEAVY;
                snk_idle_pct = IDLE_LIGHT;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // a run of frame starts crosses the periodic bitmap clear
            if (ph == 2) begin
                repeat (260) queue_item(OP_FRAME, $urandom_range(1023), $urandom_range(511),
                                        $urandom_range(65535));
            end
            counted = 0;
            while (counted < PHASE_ITEMS)
                queue_frame($urandom_range(3, 40), $urandom_range(9) != 0, counted);
            if (ph == 4) hold_request <= 1'b1;
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("greedy_point_suppression_unit: match");
        else
            $display("greedy_point_suppression_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
